// ===== hdl/b58enc_pkg.sv =====
// b58enc_pkg: shared sizes, divide-by-58 constants and the base58 alphabet
// used by the base58 encoder top level and its divide step unit
`timescale 1ns / 1ps

package b58enc_pkg;

	localparam int B58_MAX_BYTES  = 32;
	localparam int B58_MAX_DIGITS = 44;

	localparam int B58_BYTE_W  = 8;
	localparam int B58_DIGIT_W = 6;
	localparam int B58_CHAR_W  = 7;

	// cur / 58 == (cur * 18079) >> 20 for every cur below 58 * 256
	localparam int B58_RADIX       = 58;
	localparam int B58_RECIP       = 18079;
	localparam int B58_RECIP_SHIFT = 20;
	localparam int B58_CUR_W       = B58_DIGIT_W + B58_BYTE_W;
	localparam int B58_RECIP_W     = 15;
	localparam int B58_PROD_W      = B58_CUR_W + B58_RECIP_W;

	localparam logic [B58_CHAR_W-1:0] B58_ONE_CHAR = 7'h31;
	localparam logic [B58_CHAR_W-1:0] B58_ERR_CHAR = 7'h00;

	function automatic logic [B58_CHAR_W-1:0] b58_char(input logic [B58_DIGIT_W-1:0] d);
		logic [B58_CHAR_W-1:0] dd;
		logic [B58_CHAR_W-1:0] c;
		dd = {1'b0, d};
		if (dd < 7'd9) begin
			c = 7'h31 + dd;
		end else if (dd < 7'd17) begin
			c = 7'h41 + (dd - 7'd9);
		end else if (dd < 7'd22) begin
			c = 7'h4A + (dd - 7'd17);
		end else if (dd < 7'd33) begin
			c = 7'h50 + (dd - 7'd22);
		end else if (dd < 7'd44) begin
			c = 7'h61 + (dd - 7'd33);
		end else begin
			c = 7'h6D + (dd - 7'd44);
		end
		return c;
	endfunction

endpackage

// ===== hdl/b58_ram.sv =====
// b58_ram: generic single write port, single read port memory
// with registered read data; no package dependencies
`timescale 1ns / 1ps

module b58_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/b58_div.sv =====
// b58_div: one long-division step by 58 on a remainder and one byte
// depends on b58enc_pkg for the reciprocal constants
`timescale 1ns / 1ps

module b58_div import b58enc_pkg::*; (
	input  logic [B58_DIGIT_W-1:0] rem_in,
	input  logic [B58_BYTE_W-1:0]  byte_in,
	output logic [B58_BYTE_W-1:0]  quo,
	output logic [B58_DIGIT_W-1:0] rem_out
);

	logic [B58_CUR_W-1:0]  cur;
	logic [B58_PROD_W-1:0] prod;
	logic [B58_CUR_W-1:0]  back;

	assign cur  = {rem_in, byte_in};
	assign prod = B58_PROD_W'(cur) * B58_PROD_W'(B58_RECIP);
	assign quo  = prod[B58_RECIP_SHIFT +: B58_BYTE_W];
	// quo * 58 as shifts
	assign back = (B58_CUR_W'(quo) << 6) - (B58_CUR_W'(quo) << 2) - (B58_CUR_W'(quo) << 1);
	assign rem_out = B58_DIGIT_W'(cur - back);

endmodule

// ===== hdl/base58_encoder.sv =====
// channel  dir  tdata                         tlast        tuser
// s        in   [7:0] data_byte               final_byte   -
// m        out  [6:0] char_code, [7] zero     end_of_text  [0] overflow
//
// bytes load one per cycle; the encode then runs passes of the shared divide unit
// each pass divides the bytes left by 58 into one digit, about 1.37 passes per message byte
// each '1' character goes straight out, each digit character first reads the digit memory
// arst_n clears all control state; the byte and digit memories need no clearing
// s_tready is low from the final byte until the last character enters the output
// register; m_tready low holds the output register and pauses the emit sequence
//
// base58_encoder: top level, sequencer around one divide-by-58 step unit
// depends on b58enc_pkg, b58_ram and b58_div
`timescale 1ns / 1ps

module base58_encoder import b58enc_pkg::*; #(
	parameter int MAX_BYTES  = B58_MAX_BYTES,
	parameter int MAX_DIGITS = B58_MAX_DIGITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
	output logic       m_tlast,
	output logic       m_tuser    // [0] overflow
);

	localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CW  = $clog2(MAX_BYTES + 1);
	localparam int DAW = $clog2(MAX_DIGITS);
	localparam int DCW = $clog2(MAX_DIGITS + 1);
	localparam int EW  = ((CW > DCW) ? CW : DCW) + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_START = 4'd1;
	localparam logic [3:0] ST_PASS  = 4'd2;
	localparam logic [3:0] ST_DIGIT = 4'd3;
	localparam logic [3:0] ST_FIN   = 4'd4;
	localparam logic [3:0] ST_ONES  = 4'd5;
	localparam logic [3:0] ST_DRD   = 4'd6;
	localparam logic [3:0] ST_DOUT  = 4'd7;
	localparam logic [3:0] ST_ERR   = 4'd8;

	logic [3:0]             state_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          zp_q;
	logic                   pre_q;
	logic                   long_q;
	logic [CW-1:0]          ptr_q;
	logic                   vld_s1;
	logic [CW-1:0]          idx_s1;
	logic [B58_DIGIT_W-1:0] rem_q;
	logic                   found_q;
	logic [CW-1:0]          nlo_q;
	logic [DCW-1:0]         dcnt_q;
	logic [EW-1:0]          ones_q;
	logic [DCW-1:0]         dptr_q;
	logic                   ovld_q;
	logic [B58_CHAR_W-1:0]  ochar_q;
	logic                   olast_q;
	logic                   oerr_q;

	logic                   full;
	logic                   slot_free;
	logic                   emit;
	logic                   b_we;
	logic [AW-1:0]          b_waddr;
	logic [B58_BYTE_W-1:0]  b_wdata;
	logic                   b_re;
	logic [B58_BYTE_W-1:0]  b_rdata;
	logic                   d_we;
	logic                   d_re;
	logic [DCW-1:0]         dm1;
	logic [B58_DIGIT_W-1:0] d_rdata;
	logic [B58_BYTE_W-1:0]  quo;
	logic [B58_DIGIT_W-1:0] rem_n;
	logic [EW-1:0]          room;
	logic [EW-1:0]          ones_n;

	assign s_tready  = (state_q == ST_IDLE);
	assign full      = (cnt_q >= CW'(MAX_BYTES));
	assign slot_free = !ovld_q || m_tready;
	assign emit      = slot_free &&
		(state_q == ST_ONES || state_q == ST_DOUT || state_q == ST_ERR);

	assign m_tvalid = ovld_q;
	assign m_tdata  = {1'b0, ochar_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = oerr_q;

	always_comb begin
		b_we    = 1'b0;
		b_waddr = cnt_q[AW-1:0];
		b_wdata = s_tdata;
		if (state_q == ST_IDLE && s_tvalid && !full) begin
			b_we = 1'b1;
		end else if (state_q == ST_PASS && vld_s1) begin
			b_we    = 1'b1;
			b_waddr = idx_s1[AW-1:0];
			b_wdata = quo;
		end
	end

	assign b_re = (state_q == ST_PASS) && (ptr_q < cnt_q);
	assign d_we = (state_q == ST_DIGIT) && (dcnt_q < DCW'(MAX_DIGITS));
	assign d_re = (state_q == ST_DRD);
	assign dm1  = dptr_q - 1'b1;

	assign room   = EW'(MAX_DIGITS) - EW'(dcnt_q);
	assign ones_n = (EW'(zp_q) > room) ? room : EW'(zp_q);

	b58_ram #(
		.WIDTH(B58_BYTE_W),
		.DEPTH(MAX_BYTES)
	) u_byte_ram (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_waddr),
		.wdata(b_wdata),
		.re   (b_re),
		.raddr(ptr_q[AW-1:0]),
		.rdata(b_rdata)
	);

	b58_ram #(
		.WIDTH(B58_DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_digit_ram (
		.clk  (clk),
		.we   (d_we),
		.waddr(dcnt_q[DAW-1:0]),
		.wdata(rem_q),
		.re   (d_re),
		.raddr(dm1[DAW-1:0]),
		.rdata(d_rdata)
	);

	b58_div u_div (
		.rem_in (rem_q),
		.byte_in(b_rdata),
		.quo    (quo),
		.rem_out(rem_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			zp_q    <= '0;
			pre_q   <= 1'b1;
			long_q  <= 1'b0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
			rem_q   <= '0;
			found_q <= 1'b0;
			nlo_q   <= '0;
			dcnt_q  <= '0;
			ones_q  <= '0;
			dptr_q  <= '0;
			ovld_q  <= 1'b0;
			ochar_q <= '0;
			olast_q <= 1'b0;
			oerr_q  <= 1'b0;
		end else begin
			if (emit) begin
				ovld_q <= 1'b1;
			end else if (m_tready) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (!full) begin
							cnt_q <= cnt_q + 1'b1;
							if (pre_q && s_tdata == 8'd0) begin
								zp_q <= zp_q + 1'b1;
							end else begin
								pre_q <= 1'b0;
							end
						end else begin
							long_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= (full || long_q) ? ST_ERR : ST_START;
						end
					end
				end
				ST_START: begin
					dcnt_q  <= '0;
					ptr_q   <= zp_q;
					rem_q   <= '0;
					found_q <= 1'b0;
					vld_s1  <= 1'b0;
					state_q <= (zp_q == cnt_q) ? ST_FIN : ST_PASS;
				end
				ST_PASS: begin
					if (b_re) begin
						ptr_q <= ptr_q + 1'b1;
					end
					vld_s1 <= b_re;
					idx_s1 <= ptr_q;
					if (vld_s1) begin
						rem_q <= rem_n;
						if (!found_q && quo != 8'd0) begin
							found_q <= 1'b1;
							nlo_q   <= idx_s1;
						end
						if (idx_s1 == cnt_q - 1'b1) begin
							state_q <= ST_DIGIT;
						end
					end
				end
				ST_DIGIT: begin
					if (d_we) begin
						dcnt_q <= dcnt_q + 1'b1;
					end
					ptr_q   <= nlo_q;
					rem_q   <= '0;
					found_q <= 1'b0;
					vld_s1  <= 1'b0;
					state_q <= found_q ? ST_PASS : ST_FIN;
				end
				ST_FIN: begin
					ones_q  <= ones_n;
					dptr_q  <= dcnt_q;
					state_q <= (ones_n != '0) ? ST_ONES : ST_DRD;
				end
				ST_ONES: begin
					if (slot_free) begin
						ochar_q <= B58_ONE_CHAR;
						olast_q <= (ones_q == EW'(1)) && (dptr_q == '0);
						oerr_q  <= 1'b0;
						ones_q  <= ones_q - 1'b1;
						if (ones_q == EW'(1)) begin
							if (dptr_q == '0) begin
								state_q <= ST_IDLE;
								cnt_q   <= '0;
								zp_q    <= '0;
								pre_q   <= 1'b1;
								long_q  <= 1'b0;
							end else begin
								state_q <= ST_DRD;
							end
						end
					end
				end
				ST_DRD: begin
					state_q <= ST_DOUT;
				end
				ST_DOUT: begin
					if (slot_free) begin
						ochar_q <= b58_char(d_rdata);
						olast_q <= (dptr_q == DCW'(1));
						oerr_q  <= 1'b0;
						dptr_q  <= dm1;
						if (dptr_q == DCW'(1)) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							zp_q    <= '0;
							pre_q   <= 1'b1;
							long_q  <= 1'b0;
						end else begin
							state_q <= ST_DRD;
						end
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						ochar_q <= B58_ERR_CHAR;
						olast_q <= 1'b1;
						oerr_q  <= 1'b1;
						state_q <= ST_IDLE;
						cnt_q   <= '0;
						zp_q    <= '0;
						pre_q   <= 1'b1;
						long_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// error item carries no character and closes the text
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 8'd0 && m_tlast))
		else $error("error item malformed");

	// a division read in flight always points inside the stored message
	a_pass_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS && vld_s1) |-> (idx_s1 < cnt_q))
		else $error("division index beyond message");

	// digit count never passes the digit memory depth
	a_dcnt: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= DCW'(MAX_DIGITS))
		else $error("digit count overflow");

	// a new division pass never starts inside the zero prefix
	a_nlo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT && found_q) |-> (nlo_q >= zp_q && nlo_q < cnt_q))
		else $error("next pass start out of range");

endmodule
